// ===== rtl/decimal_seven_segment_scan_core_macros.svh =====
// Assertion macros shared by the display scan core
`ifndef DECIMAL_SEVEN_SEGMENT_SCAN_CORE_MACROS_SVH
`define DECIMAL_SEVEN_SEGMENT_SCAN_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define DSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dss_pkg.sv =====
// Types, constants and segment encoding for the display scan core
`timescale 1ns / 1ps

package dss_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int VALUE_W    = 27;
  localparam int POS_W      = 3;
  localparam int SYM_W      = 8;
  localparam int SEG_W      = 8;
  localparam int BCD_W      = 4;

  // floor(v / 10) = (v * DIV10_MULT) >> DIV10_SHIFT, exact for any 27-bit v
  localparam logic [VALUE_W-1:0] DIV10_MULT  = 27'd107374183;
  localparam int                 DIV10_SHIFT = 30;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

  localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
  };

  localparam logic REQ_NUMBER = 1'b0;
  localparam logic REQ_SYMBOL = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [VALUE_W-1:0] number_value;
    logic [POS_W-1:0]   digit_position;
    logic [SYM_W-1:0]   symbol_code;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] select_lines;
    logic [SEG_W-1:0] segment_pattern;
    logic             last_digit;
  } out_t;

  // Item moving through the divide chain
  typedef struct packed {
    logic                                req_type;
    logic [VALUE_W-1:0]                  rest;
    logic [POS_W-1:0]                    digit_position;
    logic [SYM_W-1:0]                    symbol_code;
    logic [MAX_DIGITS-1:0][BCD_W-1:0]    digits;
  } stg_t;

  // Item after segment encoding; a symbol request keeps its pattern in slot 0
  typedef struct packed {
    logic                             req_type;
    logic [POS_W-1:0]                 digit_position;
    logic [MAX_DIGITS-1:0][SEG_W-1:0] pats;
  } pat_t;

  function automatic logic [SEG_W-1:0] pattern_of(input logic [VALUE_W-1:0] code);
    logic [BCD_W-1:0] letter_idx;
    letter_idx = code[BCD_W-1:0] + 4'd9;  // 'A'..'F' map to table slots 10..15
    if (code <= 27'd9)
      return SEG_TABLE[code[BCD_W-1:0]];
    else if (code >= 27'd65 && code <= 27'd70)
      return SEG_TABLE[letter_idx];
    else if (code == 27'd46)
      return SEG_POINT;
    else
      return SEG_BLANK;
  endfunction

endpackage

// ===== rtl/dss_div_stage.sv =====
// One divide-by-ten pipeline stage: peels off one decimal digit
`timescale 1ns / 1ps

module dss_div_stage #(
  parameter int DIG_IDX = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  dss_pkg::stg_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output dss_pkg::stg_t dn_data
);

  localparam int PROD_W = 2 * dss_pkg::VALUE_W;

  logic                          v_r;
  dss_pkg::stg_t                 d_r;
  dss_pkg::stg_t                 d_nxt;
  logic [PROD_W-1:0]             prod;
  logic [PROD_W-dss_pkg::DIV10_SHIFT-1:0] quot;
  logic [dss_pkg::BCD_W-1:0]     q_times_ten;
  logic [dss_pkg::BCD_W-1:0]     rem;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    prod = PROD_W'(up_data.rest) * PROD_W'(dss_pkg::DIV10_MULT);
    quot = prod[PROD_W-1:dss_pkg::DIV10_SHIFT];
    // remainder is below ten, so the low nibble is enough
    q_times_ten = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    rem = up_data.rest[dss_pkg::BCD_W-1:0] - q_times_ten;
    d_nxt = up_data;
    d_nxt.rest = dss_pkg::VALUE_W'(quot);
    d_nxt.digits[3'(DIG_IDX)] = rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

// ===== rtl/dss_serializer.sv =====
// Spreads an encoded item into per-digit transactions behind an output register
`timescale 1ns / 1ps

module dss_serializer #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  dss_pkg::pat_t up_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dss_pkg::out_t out_data
);

  localparam logic [dss_pkg::POS_W-1:0] LAST_IDX = dss_pkg::POS_W'(DIGIT_COUNT - 1);

  logic                        buf_v_r;
  dss_pkg::pat_t               buf_r;
  logic [dss_pkg::POS_W-1:0]   idx_r;
  logic                        out_v_r;
  dss_pkg::out_t               out_r;
  dss_pkg::out_t               emit_nxt;
  logic                        out_load;
  logic                        buf_last;
  logic                        emit;

  assign out_load = !out_v_r || out_ready;
  assign buf_last = (buf_r.req_type == dss_pkg::REQ_SYMBOL) || (idx_r == LAST_IDX);
  assign emit     = buf_v_r && out_load;
  assign up_ready = !buf_v_r || (out_load && buf_last);

  always_comb begin
    if (buf_r.req_type == dss_pkg::REQ_SYMBOL) begin
      emit_nxt.select_lines    = ~buf_r.digit_position;
      emit_nxt.segment_pattern = buf_r.pats[0];
    end else begin
      emit_nxt.select_lines    = ~idx_r;
      emit_nxt.segment_pattern = buf_r.pats[idx_r];
    end
    emit_nxt.last_digit = buf_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_r <= buf_v_r;
      end
      if (up_valid && up_ready) begin
        buf_v_r <= 1'b1;
        idx_r   <= '0;
      end else if (emit) begin
        // drop the item once its final digit has gone out
        if (buf_last) begin
          buf_v_r <= 1'b0;
        end
        idx_r <= idx_r + dss_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      buf_r <= up_data;
    end
    if (emit) begin
      out_r <= emit_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/decimal_seven_segment_scan_core.sv =====
// Top level of the eight-digit seven-segment decimal scan core
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   dss_pkg::in_t  in_data
//   out_     output     out_valid / out_ready dss_pkg::out_t out_data
//
// A transaction can enter every cycle while the output keeps up. Its path runs
// through an input register, DIGIT_COUNT-1 divide-by-ten stages (one 27x27
// constant multiply each), an encode stage, the serializer's item buffer and
// the output register.
// A number request leaves as DIGIT_COUNT digit transactions, one digit per cycle
// while out_ready is high; a symbol request leaves as a single transaction. The output port sets the rate.
// Reset clears only valid bits and counters. A stall holds every full stage in place; empty stages still fill.
`timescale 1ns / 1ps
`include "decimal_seven_segment_scan_core_macros.svh"

module decimal_seven_segment_scan_core #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dss_pkg::out_t out_data
);

  logic [DIGIT_COUNT-1:0] ch_v;
  logic [DIGIT_COUNT-1:0] ch_rdy;
  dss_pkg::stg_t          ch_d [DIGIT_COUNT];

  logic                   s0_v_r;
  dss_pkg::stg_t          s0_r;
  dss_pkg::stg_t          s0_nxt;

  logic                   pat_v_r;
  dss_pkg::pat_t          pat_r;
  dss_pkg::pat_t          pat_nxt;
  logic                   pat_rdy;
  logic                   ser_rdy;

  // input register
  assign in_ready = !s0_v_r || ch_rdy[0];

  always_comb begin
    s0_nxt                = '0;
    s0_nxt.req_type       = in_data.req_type;
    s0_nxt.rest           = in_data.number_value;
    s0_nxt.digit_position = in_data.digit_position;
    s0_nxt.symbol_code    = in_data.symbol_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_ready) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_r <= s0_nxt;
    end
  end

  assign ch_v[0] = s0_v_r;
  assign ch_d[0] = s0_r;

  // divide chain: stage k produces the digit at position DIGIT_COUNT-k
  for (genvar k = 1; k < DIGIT_COUNT; k++) begin : g_div
    dss_div_stage #(
      .DIG_IDX (DIGIT_COUNT - k)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_v[k-1]),
      .up_ready (ch_rdy[k-1]),
      .up_data  (ch_d[k-1]),
      .dn_valid (ch_v[k]),
      .dn_ready (ch_rdy[k]),
      .dn_data  (ch_d[k])
    );
  end

  // segment encode; the leftmost digit keeps the whole quotient
  assign pat_rdy                = !pat_v_r || ser_rdy;
  assign ch_rdy[DIGIT_COUNT-1]  = pat_rdy;

  always_comb begin
    pat_nxt.req_type       = ch_d[DIGIT_COUNT-1].req_type;
    pat_nxt.digit_position = ch_d[DIGIT_COUNT-1].digit_position;
    for (int p = 0; p < dss_pkg::MAX_DIGITS; p++) begin
      if (p == 0) begin
        if (ch_d[DIGIT_COUNT-1].req_type == dss_pkg::REQ_SYMBOL) begin
          pat_nxt.pats[p] = dss_pkg::pattern_of(
            dss_pkg::VALUE_W'(ch_d[DIGIT_COUNT-1].symbol_code));
        end else begin
          pat_nxt.pats[p] = dss_pkg::pattern_of(ch_d[DIGIT_COUNT-1].rest);
        end
      end else if (p < DIGIT_COUNT) begin
        pat_nxt.pats[p] = dss_pkg::pattern_of(
          dss_pkg::VALUE_W'(ch_d[DIGIT_COUNT-1].digits[p]));
      end else begin
        pat_nxt.pats[p] = dss_pkg::SEG_BLANK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_v_r <= 1'b0;
    end else if (pat_rdy) begin
      pat_v_r <= ch_v[DIGIT_COUNT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pat_rdy && ch_v[DIGIT_COUNT-1]) begin
      pat_r <= pat_nxt;
    end
  end

  dss_serializer #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (pat_v_r),
    .up_ready  (ser_rdy),
    .up_data   (pat_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `DSS_ASSERT_NOW(a_in_block_needs_item, clk, rst_n, !in_ready, s0_v_r, "input blocked with empty input register")
  `DSS_ASSERT_NEXT(a_pat_hold, clk, rst_n, pat_v_r && !ser_rdy, pat_v_r && $stable(pat_r), "encode stage lost data on stall")
  `DSS_ASSERT_NEXT(a_digits_stream, clk, rst_n, out_valid && out_ready && !out_data.last_digit, out_valid, "gap inside a number request")

endmodule
